// File: sv/preamble_sync_length_framer_top_assert.svh
// Assertion macros used by the framer checker
`ifndef PREAMBLE_SYNC_LENGTH_FRAMER_TOP_ASSERT_SVH
`define PREAMBLE_SYNC_LENGTH_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PFR_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

// File: sv/pfr_pkg.sv
// Shared types and constants of the preamble/sync/length framer
`timescale 1ns / 1ps

package pfr_pkg;

  localparam int DEF_MAX_PREAMBLE = 32;
  localparam int DEF_SYNC_BYTES   = 4;
  // Bytes held by the sync pattern register
  localparam int SYNC_REG_BYTES   = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_BYTE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LENGTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH     = 3'd4;

  localparam logic [7:0]  RST_PREAMBLE_BYTE = 8'd85;
  localparam logic [15:0] RST_MAX_LENGTH    = 16'(3 * 2048);

  typedef struct packed {
    logic [7:0]  preamble_byte;
    logic [5:0]  preamble_count;
    logic [31:0] sync_pattern;
    logic [2:0]  sync_length;
    logic [15:0] max_length;
  } cfg_t;

  // One classified item handed from the front to the back
  typedef struct packed {
    logic        hdr;       // first item of an accepted frame
    logic [7:0]  data;      // payload byte
    logic [15:0] len;       // declared length (header only)
    logic        fend;      // payload byte closes the frame (payload only)
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_end;
  } res_t;

endpackage

// File: sv/pfr_fifo.sv
// Small register queue with full/empty flags
`timescale 1ns / 1ps

module pfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: sv/pfr_front.sv
// Front end: accepts items, tracks frame state and queues commands
`timescale 1ns / 1ps

module pfr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    payload_byte_i,
  input  logic [15:0]   frame_length_i,
  input  logic          first_of_frame_i,
  input  logic [15:0]   max_length_i,
  output logic          cmd_push_o,
  output pfr_pkg::cmd_t cmd_o
);

  logic [15:0] remaining_q, remaining_d;
  logic        dropping_q, dropping_d;

  always_comb begin
    remaining_d = remaining_q;
    dropping_d  = dropping_q;
    cmd_push_o  = 1'b0;
    cmd_o.hdr   = first_of_frame_i;
    cmd_o.data  = payload_byte_i;
    cmd_o.len   = frame_length_i;
    cmd_o.fend  = (remaining_q == 16'd1);
    if (accept_i) begin
      if (first_of_frame_i) begin
        if (frame_length_i > max_length_i) begin
          // drop the whole frame
          dropping_d  = 1'b1;
          remaining_d = '0;
        end else begin
          dropping_d  = 1'b0;
          remaining_d = (frame_length_i == '0) ? '0 : frame_length_i - 16'd1;
          cmd_push_o  = 1'b1;
        end
      end else if (!dropping_q && (remaining_q != '0)) begin
        remaining_d = remaining_q - 16'd1;
        cmd_push_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      dropping_q  <= 1'b0;
    end else begin
      remaining_q <= remaining_d;
      dropping_q  <= dropping_d;
    end
  end

endmodule

// File: sv/pfr_back.sv
// Back end: expands queued commands into the framed byte stream
`timescale 1ns / 1ps

module pfr_back #(
  parameter int MAX_PREAMBLE = pfr_pkg::DEF_MAX_PREAMBLE,
  parameter int SYNC_BYTES   = pfr_pkg::DEF_SYNC_BYTES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pfr_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  pfr_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output pfr_pkg::res_t res_o
);

  localparam int POS_W = $clog2(MAX_PREAMBLE + SYNC_BYTES + 3);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [5:0]       pre_cnt;
  logic [3:0]       sync_cnt;
  logic [POS_W-1:0] pre_end, base, sidx;
  logic             last, go;
  logic [7:0]       sync_byte;

  // Saturate the configured counts
  assign pre_cnt  = (cfg_i.preamble_count > 6'(MAX_PREAMBLE)) ?
                    6'(MAX_PREAMBLE) : cfg_i.preamble_count;
  assign sync_cnt = ({1'b0, cfg_i.sync_length} > 4'(SYNC_BYTES)) ?
                    4'(SYNC_BYTES) : {1'b0, cfg_i.sync_length};
  assign pre_end  = POS_W'(pre_cnt);
  assign base     = pre_end + POS_W'(sync_cnt);
  assign sidx     = pos_q - pre_end;

  // Sync positions past the pattern register send zero
  assign sync_byte = (sidx < POS_W'(pfr_pkg::SYNC_REG_BYTES)) ?
                     cfg_i.sync_pattern[{sidx[1:0], 3'b000} +: 8] : 8'h00;

  always_comb begin
    res_o.out_byte  = cmd_i.data;
    res_o.frame_end = cmd_i.fend;
    res_o.run_end   = 1'b1;
    last            = 1'b1;
    if (cmd_i.hdr) begin
      res_o.frame_end = 1'b0;
      res_o.run_end   = 1'b0;
      last            = 1'b0;
      if (pos_q < pre_end) begin
        res_o.out_byte = cfg_i.preamble_byte;
      end else if (pos_q < base) begin
        res_o.out_byte = sync_byte;
      end else if (pos_q == base) begin
        res_o.out_byte = cmd_i.len[15:8];
      end else if (pos_q == base + POS_W'(1)) begin
        res_o.out_byte  = cmd_i.len[7:0];
        res_o.frame_end = (cmd_i.len == '0);
        res_o.run_end   = (cmd_i.len == '0);
        last            = (cmd_i.len == '0);
      end else begin
        res_o.out_byte  = cmd_i.data;
        res_o.frame_end = (cmd_i.len == 16'd1);
        res_o.run_end   = 1'b1;
        last            = 1'b1;
      end
    end
  end

  assign go         = cmd_valid_i && !res_full_i;
  assign res_push_o = go;
  assign cmd_pop_o  = go && last;

  always_comb begin
    pos_d = pos_q;
    if (go) begin
      pos_d = last ? '0 : pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// File: sv/preamble_sync_length_framer_top.sv
// Items pass the command queue, back end and result queue. Throughput: one
// output byte per cycle while the result queue has room; a later item gives one
// byte, a first item gives preamble, sync, two length bytes and its first
// payload byte if any, set by the single byte emitter in the back end.
// Two-entry queues sit before and after it. Reset (asynchronous, active low)
// empties both queues, clears frame state and loads the register defaults.
`timescale 1ns / 1ps

module preamble_sync_length_framer_top #(
  parameter int MAX_PREAMBLE = pfr_pkg::DEF_MAX_PREAMBLE,
  parameter int SYNC_BYTES   = pfr_pkg::DEF_SYNC_BYTES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   payload_byte_i,
  input  logic [15:0]                  frame_length_i,
  input  logic                         first_of_frame_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   out_byte_o,
  output logic                         frame_end_o,
  output logic                         run_end_o
);

  localparam int CMD_W = $bits(pfr_pkg::cmd_t);
  localparam int RES_W = $bits(pfr_pkg::res_t);

  pfr_pkg::cfg_t cfg_q, cfg_d;
  pfr_pkg::cmd_t cmd_in, cmd_head;
  pfr_pkg::res_t res_in, res_head;
  logic          cmd_push, cmd_pop, cmd_empty;
  logic          res_push, res_full;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pfr_pkg::CFG_PREAMBLE_BYTE:  cfg_d.preamble_byte  = cfg_data_i[7:0];
        pfr_pkg::CFG_PREAMBLE_COUNT: cfg_d.preamble_count = cfg_data_i[5:0];
        pfr_pkg::CFG_SYNC_PATTERN:   cfg_d.sync_pattern   = cfg_data_i[31:0];
        pfr_pkg::CFG_SYNC_LENGTH:    cfg_d.sync_length    = cfg_data_i[2:0];
        pfr_pkg::CFG_MAX_LENGTH:     cfg_d.max_length     = cfg_data_i[15:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preamble_byte  <= pfr_pkg::RST_PREAMBLE_BYTE;
      cfg_q.preamble_count <= '0;
      cfg_q.sync_pattern   <= '0;
      cfg_q.sync_length    <= '0;
      cfg_q.max_length     <= pfr_pkg::RST_MAX_LENGTH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pfr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (push && !full),
    .payload_byte_i   (payload_byte_i),
    .frame_length_i   (frame_length_i),
    .first_of_frame_i (first_of_frame_i),
    .max_length_i     (cfg_q.max_length),
    .cmd_push_o       (cmd_push),
    .cmd_o            (cmd_in)
  );

  pfr_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  pfr_back #(
    .MAX_PREAMBLE (MAX_PREAMBLE),
    .SYNC_BYTES   (SYNC_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  pfr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_head),
    .empty_o (empty)
  );

  assign out_byte_o  = res_head.out_byte;
  assign frame_end_o = res_head.frame_end;
  assign run_end_o   = res_head.run_end;

endmodule

// File: sv/pfr_checker.sv
// Port-level checks of the framer, bound to the top level
`timescale 1ns / 1ps
`include "preamble_sync_length_framer_top_assert.svh"

module pfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       frame_end_o,
  input logic       run_end_o
);

  logic [9:0] res_bits;

  assign res_bits = {out_byte_o, frame_end_o, run_end_o};

  // A waiting result holds until its transfer
  `PFR_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(res_bits))

  // The end of a frame always closes the run of its item
  `PFR_ASSERT_SAME(a_fend_rend, clk_i, rst_ni, !empty && frame_end_o, run_end_o)

  // Bytes of one run follow without a gap
  `PFR_ASSERT_NEXT(a_run_gapless, clk_i, rst_ni, !empty && pop && !run_end_o, !empty)

endmodule

bind preamble_sync_length_framer_top pfr_checker u_pfr_checker (.*);

// File: dv/testbench.sv
// Self-checking testbench for the preamble/sync/length framer
`timescale 1ns / 1ps

module testbench;

  localparam int DRAIN_CYCLES = 12;
  localparam int ITEM_TARGET  = 370;
  localparam int RAND_PHASES  = 5;
  // Index with no register behind it; a write there must change nothing
  localparam logic [pfr_pkg::CFG_IDX_W-1:0] NO_REG_INDEX = 3'd5;

  class framer_scoreboard;
    logic [7:0]  pre_byte;
    logic [5:0]  pre_count;
    logic [31:0] sync_pat;
    logic [2:0]  sync_len;
    logic [15:0] len_limit;
    logic [15:0] left;
    logic        discard;
    pfr_pkg::res_t owed_bytes[$];
    int mismatches;
    int checked;
    int taken;

    function new();
      pre_byte   = pfr_pkg::RST_PREAMBLE_BYTE;
      pre_count  = '0;
      sync_pat   = '0;
      sync_len   = '0;
      len_limit  = pfr_pkg::RST_MAX_LENGTH;
      left       = '0;
      discard    = 1'b0;
      mismatches = 0;
      checked    = 0;
      taken      = 0;
    endfunction

    function void write_reg(logic [pfr_pkg::CFG_IDX_W-1:0] idx,
                            logic [pfr_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        pfr_pkg::CFG_PREAMBLE_BYTE:  pre_byte  = data[7:0];
        pfr_pkg::CFG_PREAMBLE_COUNT: pre_count = data[5:0];
        pfr_pkg::CFG_SYNC_PATTERN:   sync_pat  = data[31:0];
        pfr_pkg::CFG_SYNC_LENGTH:    sync_len  = data[2:0];
        pfr_pkg::CFG_MAX_LENGTH:     len_limit = data[15:0];
        default: ;
      endcase
    endfunction

    function void owe(logic [7:0] b, logic fend, logic rend);
      pfr_pkg::res_t r;
      r.out_byte  = b;
      r.frame_end = fend;
      r.run_end   = rend;
      owed_bytes.push_back(r);
    endfunction

    // Work out the framed bytes one accepted item causes; return how many
    function int note_item(logic [7:0] pay, logic [15:0] len, logic first);
      int n_before;
      int pc;
      int sc;
      n_before = owed_bytes.size();
      taken++;
      if (!first) begin
        if (discard || left == 0) return 0;
        left = left - 16'd1;
        owe(pay, left == 0, 1'b1);
        return 1;
      end
      if (len > len_limit) begin
        discard = 1'b1;
        left    = '0;
        return 0;
      end
      discard = 1'b0;
      pc = (pre_count > pfr_pkg::DEF_MAX_PREAMBLE) ? pfr_pkg::DEF_MAX_PREAMBLE : pre_count;
      sc = (sync_len > pfr_pkg::DEF_SYNC_BYTES) ? pfr_pkg::DEF_SYNC_BYTES : sync_len;
      for (int i = 0; i < pc; i++) owe(pre_byte, 1'b0, 1'b0);
      for (int i = 0; i < sc; i++)
        owe((i < pfr_pkg::SYNC_REG_BYTES) ? sync_pat[8*i +: 8] : 8'h00, 1'b0, 1'b0);
      owe(len[15:8], 1'b0, 1'b0);
      if (len == 0) begin
        owe(len[7:0], 1'b1, 1'b1);
        left = '0;
      end else begin
        owe(len[7:0], 1'b0, 1'b0);
        left = len - 16'd1;
        owe(pay, left == 0, 1'b1);
      end
      return owed_bytes.size() - n_before;
    endfunction

    function void check_result(logic [7:0] b, logic fend, logic rend);
      pfr_pkg::res_t e;
      checked++;
      if (owed_bytes.size() == 0) begin
        $error("unexpected output byte %02h (frame_end %0b run_end %0b)", b, fend, rend);
        mismatches++;
        return;
      end
      e = owed_bytes.pop_front();
      if (b !== e.out_byte) begin
        $error("out_byte: expected %02h, got %02h", e.out_byte, b);
        mismatches++;
      end
      if (fend !== e.frame_end) begin
        $error("frame_end: expected %0b, got %0b", e.frame_end, fend);
        mismatches++;
      end
      if (rend !== e.run_end) begin
        $error("run_end: expected %0b, got %0b", e.run_end, rend);
        mismatches++;
      end
    endfunction

    function int pending();
      return owed_bytes.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [pfr_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic [7:0] payload_byte_i = '0;
  logic [15:0] frame_length_i = '0;
  logic first_of_frame_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] out_byte_o;
  logic frame_end_o;
  logic run_end_o;

  framer_scoreboard sb = new();
  bit steady = 1'b0;
  int live_items = 0;
  int dropped_frames = 0;
  int settings_used = 1;

  preamble_sync_length_framer_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .payload_byte_i  (payload_byte_i),
    .frame_length_i  (frame_length_i),
    .first_of_frame_i(first_of_frame_i),
    .empty           (empty),
    .pop             (pop),
    .out_byte_o      (out_byte_o),
    .frame_end_o     (frame_end_o),
    .run_end_o       (run_end_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Leaves push high so back-to-back items need no second assignment
  task automatic send_item(input logic [7:0] pay, input logic [15:0] len, input logic fof);
    int gap;
    int n;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push             <= 1'b1;
    payload_byte_i   <= pay;
    frame_length_i   <= len;
    first_of_frame_i <= fof;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    n = sb.note_item(pay, len, fof);
    if (n > 0) live_items++;
    if (fof && n == 0) dropped_frames++;
  endtask

  task automatic send_frame(input int unsigned len, input int n_items);
    send_item(8'($urandom), 16'(len), 1'b1);
    for (int k = 1; k < n_items; k++) send_item(8'($urandom), 16'($urandom), 1'b0);
  endtask

  task automatic write_reg(input logic [pfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pfr_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(input logic [31:0] pb, input logic [31:0] pc,
                                input logic [31:0] sp, input logic [31:0] sl,
                                input logic [31:0] ml);
    write_reg(pfr_pkg::CFG_PREAMBLE_BYTE, pb);
    write_reg(pfr_pkg::CFG_PREAMBLE_COUNT, pc);
    write_reg(pfr_pkg::CFG_SYNC_PATTERN, sp);
    write_reg(pfr_pkg::CFG_SYNC_LENGTH, sl);
    write_reg(pfr_pkg::CFG_MAX_LENGTH, ml);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Drop push, let every owed byte out, then give dropped items time to clear
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_settings();
    logic [31:0] pc;
    logic [31:0] sl;
    logic [31:0] ml;
    int r;
    pc = $urandom;
    sl = $urandom;
    ml = $urandom;
    r = $urandom_range(0, 9);
    pc[5:0] = (r < 2) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(0, 8));
    sl[2:0] = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 9);
    if (r < 4) ml[15:0] = 16'($urandom_range(0, 30));
    else if (r < 6) ml[15:0] = pfr_pkg::RST_MAX_LENGTH;
    else if (r < 8) ml[15:0] = 16'hFFFF;
    apply_settings($urandom, pc, $urandom, sl, ml);
  endtask

  task automatic random_frame();
    int r;
    int cnt;
    int unsigned lim;
    int unsigned len;
    lim = sb.len_limit;
    r = $urandom_range(0, 99);
    if (r < 8 && lim != 16'hFFFF) begin
      // oversized: whole frame must vanish
      len = $urandom_range(lim + 1, 16'hFFFF);
      cnt = $urandom_range(1, 4);
    end else if (r < 13) begin
      // long frame abandoned after a few bytes
      len = $urandom_range(0, lim);
      cnt = $urandom_range(1, 3);
    end else if (r < 18) begin
      // stray bytes without a first item
      repeat ($urandom_range(1, 3)) send_item(8'($urandom), 16'($urandom), 1'b0);
      return;
    end else begin
      len = $urandom_range(0, (lim < 24) ? lim : 24);
      cnt = (len == 0) ? 1 : len;
      if (r < 30) cnt = cnt + $urandom_range(1, 3);
      else if (r < 38) cnt = $urandom_range(1, cnt);
    end
    send_frame(len, cnt);
  endtask

  // Result side: pop with random stalls, check each transfer
  initial begin : result_drain
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) sb.check_result(out_byte_o, frame_end_o, run_end_o);
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int goal;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: no preamble, no sync, limit 6144
    send_item(8'h3C, 16'h0000, 1'b0);
    send_item(8'hFF, 16'h0000, 1'b1);
    send_item(8'h00, 16'h0001, 1'b1);
    send_item(8'hFF, 16'h0003, 1'b1);
    send_item(8'h00, 16'hFFFF, 1'b0);
    send_item(8'hA5, 16'h0000, 1'b0);
    send_item(8'h5A, 16'h0000, 1'b0);
    send_item(8'h11, 16'd6145, 1'b1);
    send_item(8'h22, 16'h0000, 1'b0);
    send_item(8'h33, 16'd6144, 1'b1);
    send_item(8'h44, 16'h0000, 1'b0);
    send_item(8'h55, 16'h0002, 1'b1);
    send_item(8'h66, 16'h0000, 1'b0);
    wait_idle();

    // Full preamble, full sync word, no length limit
    apply_settings(32'hFF, 32'd32, 32'hF0E1_D2C3, 32'd4, 32'hFFFF);
    send_item(8'h00, 16'hFFFF, 1'b1);
    send_item(8'hFF, 16'h1234, 1'b0);
    send_item(8'h77, 16'h0000, 1'b1);
    wait_idle();

    // Saturated counts, limit zero: only empty frames pass
    write_reg(NO_REG_INDEX, 32'hFFFF_FFFF);
    apply_settings(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_item(8'h99, 16'h0000, 1'b1);
    send_item(8'h88, 16'h0001, 1'b1);
    send_item(8'h12, 16'h0000, 1'b0);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      steady = (p == 0);
      random_settings();
      goal = ITEM_TARGET * (p + 1) / RAND_PHASES;
      while (sb.taken < goal) random_frame();
      wait_idle();
    end
    steady = 1'b0;

    $display("Covered %0d register settings, %0d input items (%0d gave output).",
             settings_used, sb.taken, live_items);
    $display("Dropped %0d frames; checked %0d output bytes, %0d mismatches.",
             dropped_frames, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
